[rtl/lif_pkg.sv]
`default_nettype none
package lif_pkg;
  localparam int NRecep = 2;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_THRESH  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RESETV  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_REFR    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DECAY   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_GAIN    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_REST    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_COEFF0  = 3'd6;
  localparam logic [RegIdxW-1:0] REG_COEFF1  = 3'd7;

  // Multiply request to the shared unit: signed 33-bit operand times unsigned 25-bit
  // coefficient, shifted right with round-half-up by 16 or 24.
  typedef struct packed {
    logic signed [32:0] a;
    logic [24:0]        b;
    logic               shift24;
  } mul_req_t;

  // Divider control.
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

[rtl/lif_mul.sv]
`default_nettype none
module lif_mul (
  input  wire logic                clk,
  input  wire lif_pkg::mul_req_t   req,
  output logic signed [63:0]       prod
);
  import lif_pkg::*;

  logic signed [58:0] p;
  logic signed [58:0] rnd;

  // One signed product, rounded and registered.
  always_comb begin
    p = 59'(req.a) * $signed({1'b0, req.b});
    rnd = req.shift24 ? (p + 59'sd8388608) >>> 24 : (p + 59'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    prod <= 64'(rnd);
  end
endmodule
`default_nettype wire

[rtl/lif_div.sv]
`default_nettype none
module lif_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lif_pkg::div_req_t req,
  output logic                   busy,
  output logic [15:0]            quot
);
  import lif_pkg::*;

  // Restoring divider, one quotient bit per cycle; only 17 bits matter
  // since the result is capped at 65535.
  logic [33:0] rem;
  logic [32:0] den;
  logic [16:0] q;
  logic [4:0]  cnt;
  logic [33:0] shifted;
  logic [33:0] trial;

  // The first step compares the numerator itself, so its bit carries the
  // integer part; the remaining 16 steps give the fraction bits.
  always_comb begin
    shifted = (cnt == 5'd17) ? rem : {rem[32:0], 1'b0};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 5'd17;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // Both operands are positive here. When the numerator is not below
      // the denominator, the integer bit is set and the result is capped.
      rem <= {1'b0, req.num};
      den <= req.den;
      q   <= '0;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        q   <= {q[15:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[15:0], 1'b0};
      end
    end
  end

  assign quot = q[16] ? 16'hffff : q[15:0];
endmodule
`default_nettype wire

[rtl/lif_neuron_alpha_synapse_step.sv]
`default_nettype none
// Channel  Dir  Contents
// s_axis   in   tdata: input_current, spike_weight_0, spike_weight_1
// m_axis   out  tdata: spiked, crossing_frac, membrane_voltage
// cfg      in   we, idx, wdata
// One tick issues twelve products through the shared multiplier, one per
// cycle. A spike with a rising membrane also passes through the 17-bit
// serial divider. The block takes a new request only when idle and its
// result register is empty. Reset is synchronous; the FSM, neuron state,
// output valid and configuration registers return to defaults, while
// datapath holding registers are not reset.
module lif_neuron_alpha_synapse_step (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // input_current, spike_weight_0, spike_weight_1
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [55:0]       m_axis_tdata,  // spiked, crossing_frac, membrane_voltage, zero pad
  input  wire logic         we,
  input  wire logic [lif_pkg::RegIdxW-1:0] idx,
  input  wire logic [63:0]  wdata
);
  import lif_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SUM = 3'd2,
                         S_DIV = 3'd3, S_OUT = 3'd4;

  // Configuration registers.
  logic signed [31:0] threshold, reset_voltage, rest_drive;
  logic [15:0] refractory_steps;
  logic [16:0] voltage_decay;
  logic [23:0] current_gain;
  logic [63:0] coeff [NRecep];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 32'sd1736704;
      reset_voltage <= '0;
      refractory_steps <= 16'd5;
      voltage_decay <= 17'd65226;
      current_gain <= 24'd16915;
      rest_drive <= -32'sd24103;
      coeff[0] <= '0;
      coeff[1] <= '0;
    end else if (we) begin
      case (idx)
        REG_THRESH: threshold <= wdata[31:0];
        REG_RESETV: reset_voltage <= wdata[31:0];
        REG_REFR:   refractory_steps <= wdata[15:0];
        REG_DECAY:  voltage_decay <= wdata[16:0];
        REG_GAIN:   current_gain <= wdata[23:0];
        REG_REST:   rest_drive <= wdata[31:0];
        REG_COEFF0: coeff[0] <= wdata;
        REG_COEFF1: coeff[1] <= wdata;
        default: ;
      endcase
    end
  end

  // Neuron state.
  logic signed [31:0] membrane, held_current;
  logic [15:0] refr_left;
  logic signed [31:0] rise [NRecep];
  logic signed [31:0] shape [NRecep];
  logic signed [31:0] w_in [NRecep];
  logic signed [31:0] cur_in;

  logic [2:0] state;
  logic [3:0] step;
  logic signed [63:0] acc, rise_part [NRecep];
  logic signed [63:0] prod;
  mul_req_t mreq;
  div_req_t dreq;
  logic dbusy;
  logic [15:0] dquot;
  logic signed [31:0] v_old;
  logic spk;
  logic dquot_valid;

  lif_mul u_mul (.clk(clk), .req(mreq), .prod(prod));
  lif_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot));

  // Multiply schedule: step k issues, step k+1 collects.
  // 0 decay*v, 1 gain*I, 2,3 rise/shape coupling r0, 4,5 r1,
  // 6 d0*rise0, 7 d0*(rise0+shape0), 8 s0*w0, 9..11 receptor 1.
  logic [0:0] rsel;
  logic [15:0] cf [4];
  always_comb begin
    rsel = (step >= 4'd9 || step == 4'd4 || step == 4'd5) ? 1'b1 : 1'b0;
    for (int k = 0; k < 4; k++) cf[k] = coeff[rsel][16*k +: 16];
    mreq.shift24 = 1'b0;
    mreq.a = '0;
    mreq.b = '0;
    case (step)
      4'd0: begin mreq.a = 33'(v_old); mreq.b = 25'(voltage_decay); end
      4'd1: begin mreq.a = 33'(held_current); mreq.b = 25'(current_gain);
                  mreq.shift24 = 1'b1; end
      4'd2, 4'd4: begin mreq.a = 33'(rise[rsel]); mreq.b = 25'(cf[1]); end
      4'd3, 4'd5: begin mreq.a = 33'(shape[rsel]); mreq.b = 25'(cf[2]); end
      4'd6, 4'd9: begin mreq.a = 33'(rise[rsel]); mreq.b = 25'(cf[0]); end
      4'd7, 4'd10: begin mreq.a = 33'(rise[rsel]) + 33'(shape[rsel]);
                         mreq.b = 25'(cf[0]); end
      4'd8, 4'd11: begin mreq.a = 33'(w_in[rsel]); mreq.b = 25'(cf[3]); end
      default: ;
    endcase
  end

  logic signed [31:0] vsat;
  logic signed [32:0] num, den;
  always_comb begin
    vsat = sat32(acc);
    num = 33'(vsat) - 33'(threshold);
    den = 33'(vsat) - 33'(v_old);
    dreq.start = 1'b0;
    dreq.num = num;
    dreq.den = den;
    if (state == S_SUM && refr_left == 16'd0 && vsat > threshold && den > 0)
      dreq.start = 1'b1;
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      membrane <= '0;
      held_current <= '0;
      refr_left <= '0;
      for (int r = 0; r < NRecep; r++) begin
        rise[r] <= '0;
        shape[r] <= '0;
      end
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cur_in <= s_axis_tdata[31:0];
          w_in[0] <= s_axis_tdata[63:32];
          w_in[1] <= s_axis_tdata[95:64];
          v_old <= membrane;
          acc <= 64'(rest_drive);
          step <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // collect the product issued last cycle
          if (step >= 4'd1) begin
            case (step - 4'd1)
              4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: acc <= acc + prod;
              4'd6: rise_part[0] <= prod;
              4'd7: shape[0] <= sat32(prod);
              4'd8: rise[0] <= sat32(rise_part[0] + prod);
              4'd9: rise_part[1] <= prod;
              4'd10: shape[1] <= sat32(prod);
              default: rise[1] <= sat32(rise_part[1] + prod);
            endcase
          end
          // synaptic update needs old rise/shape: membrane terms run first
          if (step == 4'd12) state <= S_SUM;
          else step <= step + 4'd1;
        end
        S_SUM: begin
          held_current <= cur_in;
          spk <= 1'b0;
          if (refr_left != 16'd0) begin
            refr_left <= refr_left - 16'd1;
            membrane <= (refr_left == 16'd1) ? reset_voltage : v_old;
            state <= S_OUT;
          end else begin
            membrane <= vsat;
            if (vsat > threshold) begin
              spk <= 1'b1;
              refr_left <= refractory_steps;
              state <= (den > 0) ? S_DIV : S_OUT;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_DIV: if (!dbusy) state <= S_OUT;
        default: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {7'd0, membrane, (spk ? ((refr_left == refractory_steps
                           && dquot_valid) ? dquot : 16'hffff) : 16'd0), spk};
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Marks that the current tick's spike went through the divider.
  always_ff @(posedge clk) begin
    if (rst) dquot_valid <= 1'b0;
    else if (state == S_SUM) dquot_valid <= dreq.start;
  end
endmodule
`default_nettype wire
